// ----- hw/rtl/ritoa_pkg.sv -----
// ----------------------------------------------------------------------------
// ritoa_pkg
// Shared types, constants and helpers for the radix integer-to-ASCII block.
// ----------------------------------------------------------------------------
package ritoa_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 64;
  localparam int unsigned VALUE_BITS_DEF = 64;

  localparam int unsigned IN_W     = 64;  // input value field
  localparam int unsigned CHAR_W   = 7;   // char_code field
  localparam int unsigned CNT_W    = 7;   // digit_count / position counters
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned MINW_W   = 7;
  localparam int unsigned CFG_W    = 7;   // widest register
  localparam int unsigned OUT_W    = 16;  // char_code + digit_count, byte padded

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RST   = 6'd16;
  localparam logic [MINW_W-1:0]  MIN_W_RST   = 7'd16;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h41;  // 'A'
  localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;

  // register indexes
  localparam logic REG_RADIX     = 1'b0;
  localparam logic REG_MIN_WIDTH = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // take new value, clear digit count
    logic div_step;  // one restoring division bit
    logic store;     // write digit, reset divider
    logic prep;      // work out first output position
    logic rd;        // read digit at current position
    logic next;      // step to next position
  } ritoa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bits_done;  // last division bit this cycle
    logic quot_zero;  // running quotient is zero
    logic pos_zero;   // current position is the final character
  } ritoa_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/radix_integer_to_ascii_top.sv -----
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_top
// Converts an unsigned value to ASCII digits in a configurable base (2..36),
// most significant first, left-padded with '0' to a minimum width.
// ----------------------------------------------------------------------------
//  channel   dir  word contents (low bit first)
//  s_axis    in   tdata[63:0] value
//  m_axis    out  tdata[6:0] char_code, [13:7] digit_count, [15:14] zero;
//                 tlast = final character of the string
//  cfg       in   cfg_we_i, cfg_idx_i (0 radix, 1 min_width), cfg_data_i[6:0]
//
//  One value at a time. Each digit comes from the bit-serial divider (one
//  quotient bit a cycle) and is then stored; after the last digit a setup
//  step picks the first output position, then each character is a digit
//  store read followed by the word on m_axis, which an m_axis stall can hold.
//  Reset: radix 16, min_width 16; the digit store needs no clearing pass,
//  every entry whose digit is used for a value is written earlier for that value.
//  s_axis_tready is high only while idle; m_axis words hold while stalled.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_top
  import ritoa_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF,  // 16..64
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF   // 8..64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // config write port
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // [63:0] value
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // [6:0] char_code, [13:7] digit_count
  output logic              m_axis_tlast
);

  ritoa_cmd_t        cmd;
  ritoa_stat_t       stat;
  logic [CHAR_W-1:0] char_code;
  logic [CNT_W-1:0]  digit_count;

  ritoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ritoa_dp #(
    .MAX_DIGITS(MAX_DIGITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .value_i      (s_axis_tdata),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .char_code_o  (char_code),
    .digit_count_o(digit_count)
  );

  // pad bits above the two fields
  assign m_axis_tdata = {(OUT_W - CHAR_W - CNT_W)'(0), digit_count, char_code};
  // position zero is the final character
  assign m_axis_tlast = stat.pos_zero;

endmodule

// ----- hw/rtl/ritoa_ram.sv -----
// ----------------------------------------------------------------------------
// ritoa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ritoa_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ritoa_dp.sv -----
// ----------------------------------------------------------------------------
// ritoa_dp
// Datapath: config registers, bit-serial divider, digit store, output select.
// ----------------------------------------------------------------------------
module ritoa_dp
  import ritoa_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic [IN_W-1:0]   value_i,
  input  ritoa_cmd_t        cmd_i,
  output ritoa_stat_t       stat_o,
  output logic [CHAR_W-1:0] char_code_o,
  output logic [CNT_W-1:0]  digit_count_o
);

  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
  localparam int unsigned BIT_W = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_DIGITS);
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(VALUE_BITS - 1);

  logic [RADIX_W-1:0]    radix_q;
  logic [MINW_W-1:0]     min_width_q;
  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [RADIX_W-1:0]    rem_q, rem_d;
  logic [BIT_W-1:0]      bit_q;
  logic [CNT_W-1:0]      n_q;
  logic [CNT_W-1:0]      pos_q;
  logic [RADIX_W:0]      trial;
  logic                  ge;
  logic [RADIX_W-1:0]    cfg_radix;
  logic [CNT_W-1:0]      width_eff;
  logic [CNT_W-1:0]      total;
  logic [RADIX_W-1:0]    rd_digit;

  // clamp radix writes to 2..36
  always_comb begin
    cfg_radix = cfg_data_i[RADIX_W-1:0];
    if (cfg_radix < RADIX_MIN) cfg_radix = RADIX_MIN;
    if (cfg_radix > RADIX_MAX) cfg_radix = RADIX_MAX;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RADIX_RST;
      min_width_q <= MIN_W_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIX:     radix_q     <= cfg_radix;
        REG_MIN_WIDTH: min_width_q <= cfg_data_i[MINW_W-1:0];
        default: ;
      endcase
    end
  end

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial  = {rem_q, quot_q[VALUE_BITS-1]};
    ge     = trial >= {1'b0, radix_q};
    rem_d  = ge ? RADIX_W'(trial - {1'b0, radix_q}) : trial[RADIX_W-1:0];
    quot_d = {quot_q[VALUE_BITS-2:0], ge};
  end

  always_comb begin
    width_eff = (min_width_q > MAX_CNT) ? MAX_CNT : min_width_q;
    total     = (n_q > width_eff) ? n_q : width_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      rem_q  <= '0;
      bit_q  <= '0;
      n_q    <= '0;
      pos_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        quot_q <= value_i[VALUE_BITS-1:0];
        rem_q  <= '0;
        bit_q  <= '0;
        n_q    <= '0;
      end else if (cmd_i.div_step) begin
        quot_q <= quot_d;
        rem_q  <= rem_d;
        bit_q  <= bit_q + 1'b1;
      end else if (cmd_i.store) begin
        rem_q <= '0;
        bit_q <= '0;
        if (n_q < MAX_CNT) n_q <= n_q + 1'b1;  // excess high digits dropped
      end
      if (cmd_i.prep) begin
        pos_q <= total - 1'b1;
      end else if (cmd_i.next) begin
        pos_q <= pos_q - 1'b1;
      end
    end
  end

  ritoa_ram #(
    .WIDTH(RADIX_W),
    .DEPTH(MAX_DIGITS)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store && (n_q < MAX_CNT)),
    .waddr_i(n_q[IDX_W-1:0]),
    .wdata_i(rem_q),
    .re_i   (cmd_i.rd),
    .raddr_i(pos_q[IDX_W-1:0]),
    .rdata_o(rd_digit)
  );

  assign stat_o.bits_done = (bit_q == LAST_BIT);
  assign stat_o.quot_zero = (quot_q == '0);
  assign stat_o.pos_zero  = (pos_q == '0);

  // positions at or above the digit count are leading padding
  assign char_code_o   = (pos_q >= n_q) ? CHAR_ZERO : digit_char(rd_digit);
  assign digit_count_o = n_q;

endmodule

// ----- hw/rtl/ritoa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ritoa_ctrl
// Sequencer: accept, divide per digit, then emit one word per character.
// ----------------------------------------------------------------------------
module ritoa_ctrl
  import ritoa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  ritoa_stat_t stat_i,
  output ritoa_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_STORE = 6'b000100,
    ST_PREP  = 6'b001000,
    ST_RD    = 6'b010000,
    ST_SEND  = 6'b100000
  } ritoa_state_e;

  ritoa_state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.bits_done) state_d = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = stat_i.quot_zero ? ST_PREP : ST_DIV;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_SEND;
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.pos_zero) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.next = 1'b1;
            state_d    = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for radix_integer_to_ascii_top. A table of directed
// values and register writes is played first: extremes, base clamping, wide
// padding and zero. Random phases follow, each with its own base and minimum
// width. Values are spelt out by a local model of the converter, or by the
// table text where given; m_axis words are checked in order against these.
// ----------------------------------------------------------------------------
module tb_top
  import ritoa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned DIGIT_CAP   = MAX_DIGITS_DEF;
  localparam int unsigned TXT_CHARS   = 24;
  localparam int unsigned TXT_W       = 8 * TXT_CHARS;
  localparam int unsigned N_DIR       = 32;

  typedef enum logic {ROW_REG, ROW_VALUE} row_kind_e;

  // One directed step. A value row with txt_len zero is left to the model;
  // otherwise txt holds the expected string, right-aligned.
  typedef struct packed {
    row_kind_e          kind;
    logic               reg_idx;
    logic [CFG_W-1:0]   reg_data;
    logic [IN_W-1:0]    value;
    logic [4:0]         txt_len;
    logic [TXT_W-1:0]   txt;
    logic [CNT_W-1:0]   count;
  } dir_row_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  char_code;
    logic               last;
    logic [CNT_W-1:0]   digit_count;
  } char_word_t;

  // Directed table: reset settings first (base 16, width 16), then clamping
  // of the base at both ends, oversized minimum widths and padding.
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'd0, 5'd16, TXT_W'("0000000000000000"), 7'd1},
    '{ROW_VALUE, REG_RADIX, 7'd0, '1, 5'd16, TXT_W'("FFFFFFFFFFFFFFFF"), 7'd16},
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'hFEDC_BA98_7654_3210, 5'd16,
      TXT_W'("FEDCBA9876543210"), 7'd16},
    '{ROW_REG, REG_MIN_WIDTH, 7'd0, 64'd0, 5'd0, '0, 7'd0},
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'd0, 5'd1, TXT_W'("0"), 7'd1},
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'h0123_4567_89AB_CDEF, 5'd15,
      TXT_W'("123456789ABCDEF"), 7'd15},
    '{ROW_REG, REG_RADIX, 7'd1, 64'd0, 5'd0, '0, 7'd0},      // below range
    '{ROW_VALUE, REG_RADIX, 7'd0, '1, 5'd0, '0, 7'd0},       // 64 digits
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'h8000_0000_0000_0000, 5'd0, '0, 7'd0},
    '{ROW_REG, REG_RADIX, 7'd0, 64'd0, 5'd0, '0, 7'd0},
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'd5, 5'd3, TXT_W'("101"), 7'd3},
    '{ROW_REG, REG_RADIX, 7'd37, 64'd0, 5'd0, '0, 7'd0},     // above range
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'd35, 5'd1, TXT_W'("Z"), 7'd1},
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'd36, 5'd2, TXT_W'("10"), 7'd2},
    '{ROW_VALUE, REG_RADIX, 7'd0, '1, 5'd0, '0, 7'd0},
    '{ROW_REG, REG_RADIX, 7'h7F, 64'd0, 5'd0, '0, 7'd0},     // masks to 63
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'd1295, 5'd2, TXT_W'("ZZ"), 7'd2},
    '{ROW_REG, REG_RADIX, 7'h40, 64'd0, 5'd0, '0, 7'd0},     // masks to 0
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'd2, 5'd2, TXT_W'("10"), 7'd2},
    '{ROW_REG, REG_RADIX, 7'd10, 64'd0, 5'd0, '0, 7'd0},
    '{ROW_REG, REG_MIN_WIDTH, 7'd127, 64'd0, 5'd0, '0, 7'd0},
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'd0, 5'd0, '0, 7'd0},    // 64 pad chars
    '{ROW_REG, REG_MIN_WIDTH, 7'd64, 64'd0, 5'd0, '0, 7'd0},
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'd1234567890, 5'd0, '0, 7'd0},
    '{ROW_REG, REG_MIN_WIDTH, 7'd3, 64'd0, 5'd0, '0, 7'd0},
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'd7, 5'd3, TXT_W'("007"), 7'd1},
    '{ROW_VALUE, REG_RADIX, 7'd0, '1, 5'd20, TXT_W'("18446744073709551615"), 7'd20},
    '{ROW_REG, REG_MIN_WIDTH, 7'h55, 64'd0, 5'd0, '0, 7'd0},
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'd9, 5'd0, '0, 7'd0},
    '{ROW_REG, REG_RADIX, 7'd8, 64'd0, 5'd0, '0, 7'd0},
    '{ROW_REG, REG_MIN_WIDTH, 7'd5, 64'd0, 5'd0, '0, 7'd0},
    '{ROW_VALUE, REG_RADIX, 7'd0, 64'd511, 5'd5, TXT_W'("00777"), 7'd3}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               m_axis_tlast;

  // Local copy of the converter's settings, updated on every register write
  logic [RADIX_W-1:0] radix_set;
  logic [MINW_W-1:0]  width_set;

  char_word_t         chars_due [$];   // words still to come, oldest first
  char_word_t         head_word;
  int unsigned        mismatches;
  int unsigned        cycle_cnt;
  bit                 gaps_on;         // sender may idle
  bit                 stall_on;        // receiver may stall

  radix_integer_to_ascii_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Spell a value in the current base and queue its words. Digits are
  // gathered least significant first, then emitted from the top, with '0'
  // padding in front up to the effective minimum width (capped at 64).
  task automatic spell_value(input logic [IN_W-1:0] v);
    logic [RADIX_W-1:0] digs [DIGIT_CAP];
    logic [IN_W-1:0]    quot;
    logic [RADIX_W-1:0] d;
    int unsigned        n;
    int unsigned        wid;
    int unsigned        total;
    int unsigned        pos;
    int unsigned        k;
    char_word_t         w;
    quot = v;
    n    = 0;
    do begin
      d    = RADIX_W'(quot % IN_W'(radix_set));
      quot = quot / IN_W'(radix_set);
      if (n < DIGIT_CAP) begin
        digs[n] = d;
        n++;
      end
    end while (quot != 0);
    wid   = (width_set > MINW_W'(DIGIT_CAP)) ? DIGIT_CAP : int'(width_set);
    total = (n > wid) ? n : wid;
    for (k = 0; k < total; k++) begin
      pos = total - 1 - k;
      if (pos >= n) begin
        w.char_code = CHAR_ZERO;
      end else if (digs[pos] < 6'd10) begin
        w.char_code = CHAR_ZERO + CHAR_W'(digs[pos]);
      end else begin
        w.char_code = CHAR_A + CHAR_W'(digs[pos] - 6'd10);
      end
      w.last        = (k == total - 1);
      w.digit_count = CNT_W'(n);
      chars_due.push_back(w);
    end
  endtask

  // Register write; the local settings follow the clamping rules
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    logic [RADIX_W-1:0] r;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_RADIX) begin
      r = data[RADIX_W-1:0];
      if (r < RADIX_MIN) begin
        r = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
        r = RADIX_MAX;
      end
      radix_set = r;
    end else begin
      width_set = data;
    end
  endtask

  // Offer one value; tvalid stays high after the accept so that a
  // back-to-back word needs no lowering.
  task automatic push_value(input logic [IN_W-1:0] v);
    if (gaps_on && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 17);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off until every queued word is back and the block is idle.
  // tready is low while the last word goes out, so the exit cycle does not
  // depend on when the checker pops that word.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (chars_due.size() != 0 || !s_axis_tready);
  endtask

  // Receiver: random stalls, and the word check
  always @(posedge clk_i) begin
    m_axis_tready <= !(stall_on && $urandom_range(99) < 17);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (chars_due.size() == 0) begin
        $error("unexpected word: char_code %h digit_count %0d last %b",
               m_axis_tdata[CHAR_W-1:0], m_axis_tdata[CHAR_W+CNT_W-1:CHAR_W],
               m_axis_tlast);
        mismatches++;
      end else begin
        head_word = chars_due.pop_front();
        if (m_axis_tdata[CHAR_W-1:0] !== head_word.char_code) begin
          $error("char_code: expected %h, got %h", head_word.char_code,
                 m_axis_tdata[CHAR_W-1:0]);
          mismatches++;
        end
        if (m_axis_tlast !== head_word.last) begin
          $error("last: expected %b, got %b", head_word.last, m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tdata[CHAR_W+CNT_W-1:CHAR_W] !== head_word.digit_count) begin
          $error("digit_count: expected %0d, got %0d", head_word.digit_count,
                 m_axis_tdata[CHAR_W+CNT_W-1:CHAR_W]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    dir_row_t          row;
    char_word_t        w;
    logic [IN_W-1:0]   v;
    logic [CFG_W-1:0]  rdx;
    logic [CFG_W-1:0]  mw;
    int unsigned       k;
    int unsigned       ph;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_RADIX;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    cycle_cnt     = 0;
    radix_set     = RADIX_RST;
    width_set     = MIN_W_RST;
    gaps_on       = 1'b1;
    stall_on      = 1'b1;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; registers only change once the block has gone idle
    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_REG) begin
        drain();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        push_value(row.value);
        if (row.txt_len == 0) begin
          spell_value(row.value);
        end else begin
          for (k = 0; k < row.txt_len; k++) begin
            w.char_code   = row.txt[8*(row.txt_len-1-k) +: CHAR_W];
            w.last        = (k == row.txt_len - 1);
            w.digit_count = row.count;
            chars_due.push_back(w);
          end
        end
      end
    end

    // Random phases. Phase 0 and 1 pin the base at its extremes, phase 2
    // pads everything to 64, phase 4 runs flat out on both sides.
    // Value lengths are spread so that slow base-2 runs stay a minority.
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       rdx = 7'd2;
        1:       rdx = 7'd36;
        default: rdx = ($urandom_range(7) == 0) ? CFG_W'($urandom)
                                                : CFG_W'($urandom_range(2, 36));
      endcase
      if (ph == 2) begin
        mw = 7'd64;
      end else begin
        mw = ($urandom_range(5) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(24));
      end
      drain();
      write_reg(REG_RADIX, rdx);
      write_reg(REG_MIN_WIDTH, mw);
      gaps_on  = (ph != 4);
      stall_on = (ph != 4);
      repeat (17) begin
        case ($urandom_range(15))
          0:          v = '0;
          1:          v = '1;
          2, 3, 4, 5: v = {$urandom, $urandom};
          default:    v = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        push_value(v);
        spell_value(v);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && chars_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ritoa_pkg.sv
hw/rtl/ritoa_ram.sv
hw/rtl/ritoa_dp.sv
hw/rtl/ritoa_ctrl.sv
hw/rtl/radix_integer_to_ascii_top.sv
tb/tb_top.sv
